// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the deque modules. Both expect signals named
// clk and rst_n in the scope where they are used, and are off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CDQ_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CDQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cdq_pkg.sv =====
package cdq_pkg;

  // Default geometry of the store.
  localparam int CDQ_CAPACITY   = 64;
  localparam int CDQ_DATA_WIDTH = 32;

  // Field widths of the streaming items.
  localparam int KIND_W   = 4;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 6;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  localparam int IN_FIELDS_W  = VALUE_W + INDEX_W + COUNT_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = VALUE_W + COUNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Operation kinds carried on in_tuser.
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 4'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 4'd1;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 4'd2;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 4'd3;
  localparam logic [KIND_W-1:0] KIND_READ_FRONT = 4'd4;
  localparam logic [KIND_W-1:0] KIND_READ_BACK  = 4'd5;
  localparam logic [KIND_W-1:0] KIND_READ_AT    = 4'd6;
  localparam logic [KIND_W-1:0] KIND_CLEAR      = 4'd7;
  localparam logic [KIND_W-1:0] KIND_RESIZE     = 4'd8;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  // Datapath operations issued by the controller.
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 4'd1;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 4'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 4'd3;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 4'd4;
  localparam logic [OP_W-1:0] OP_READ_FRONT = 4'd5;
  localparam logic [OP_W-1:0] OP_READ_BACK  = 4'd6;
  localparam logic [OP_W-1:0] OP_READ_AT    = 4'd7;
  localparam logic [OP_W-1:0] OP_CLEAR      = 4'd8;
  localparam logic [OP_W-1:0] OP_SHRINK     = 4'd9;
  localparam logic [OP_W-1:0] OP_FILL_START = 4'd10;
  localparam logic [OP_W-1:0] OP_FILL_STEP  = 4'd11;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic                ld_out;   // load the result register this cycle
    logic                out_ram;  // result data comes from the store read port
    logic [STATUS_W-1:0] status;
  } cdq_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic idx_ok;      // read_at index is below the element count
    logic cnt_over;    // resize target above capacity
    logic cnt_grow;    // resize target above element count
    logic cnt_shrink;  // resize target below element count
    logic fill_last;   // the current fill write reaches the target
  } cdq_flags_t;

endpackage

// ===== rtl/cdq_ram.sv =====
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/cdq_dp.sv =====
`include "assert_macros.svh"

module cdq_dp import cdq_pkg::*; #(
  parameter int CAPACITY   = CDQ_CAPACITY,
  parameter int DATA_WIDTH = CDQ_DATA_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cdq_cmd_t            cmd,
  output cdq_flags_t          flags,
  input  logic [VALUE_W-1:0]  in_value,
  input  logic [INDEX_W-1:0]  in_index,
  input  logic [COUNT_W-1:0]  in_count,
  output logic [VALUE_W-1:0]  res_data,
  output logic [COUNT_W-1:0]  res_occupancy,
  output logic [STATUS_W-1:0] res_status
);

  localparam int PTR_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int WRAP_W = PTR_W + 2;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CAPACITY - 1);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? LAST_PTR : p - 1'b1;
  endfunction

  logic [PTR_W-1:0]      head_r, head_nxt;
  logic [PTR_W-1:0]      tail_r, tail_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      count_inc, count_dec;
  logic [VALUE_W-1:0]    fill_val_r;
  logic [CNT_W-1:0]      fill_tgt_r;
  logic [VALUE_W-1:0]    data_r;
  logic [COUNT_W-1:0]    occ_r;
  logic [STATUS_W-1:0]   stat_r;

  logic [CMP_W-1:0]      count_cmp, req_cmp, idx_cmp;
  logic [PTR_W:0]        at_sum;
  logic [PTR_W-1:0]      at_ptr;
  logic [CNT_W-1:0]      drop;
  logic [WRAP_W-1:0]     shr_sum;
  logic [PTR_W-1:0]      shr_ptr;

  logic                  wr_en, rd_en;
  logic [PTR_W-1:0]      wr_addr, rd_addr;
  logic [VALUE_W-1:0]    wr_value;
  logic [DATA_WIDTH-1:0] rd_data;

  assign count_cmp = CMP_W'(count_r);
  assign req_cmp   = CMP_W'(in_count);
  assign idx_cmp   = CMP_W'(in_index);
  assign count_inc = count_r + 1'b1;
  assign count_dec = count_r - 1'b1;

  assign flags.empty      = (count_r == '0);
  assign flags.full       = (count_r == CNT_W'(CAPACITY));
  assign flags.idx_ok     = (idx_cmp < count_cmp);
  assign flags.cnt_over   = (req_cmp > CMP_W'(CAPACITY));
  assign flags.cnt_grow   = (req_cmp > count_cmp);
  assign flags.cnt_shrink = (req_cmp < count_cmp);
  assign flags.fill_last  = (count_inc == fill_tgt_r);

  // Position of the indexed element; only used when the index is in range,
  // so it stays below the capacity and fits a pointer.
  assign at_sum = {1'b0, head_r} + {1'b0, PTR_W'(in_index)};
  assign at_ptr = (at_sum >= (PTR_W+1)'(CAPACITY)) ?
                  PTR_W'(at_sum - (PTR_W+1)'(CAPACITY)) : at_sum[PTR_W-1:0];

  // Truncation moves the back pointer down by the number of dropped entries.
  assign drop    = count_r - CNT_W'(in_count);
  assign shr_sum = WRAP_W'(tail_r) + WRAP_W'(CAPACITY) - WRAP_W'(drop);
  assign shr_ptr = (shr_sum >= WRAP_W'(CAPACITY)) ?
                   PTR_W'(shr_sum - WRAP_W'(CAPACITY)) : shr_sum[PTR_W-1:0];

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    wr_en     = 1'b0;
    wr_addr   = tail_r;
    wr_value  = in_value;
    rd_en     = 1'b0;
    rd_addr   = head_r;
    unique case (cmd.op)
      OP_PUSH_BACK, OP_FILL_STEP: begin
        tail_nxt  = ptr_inc(tail_r);
        wr_en     = 1'b1;
        wr_addr   = tail_nxt;
        wr_value  = (cmd.op == OP_FILL_STEP) ? fill_val_r : in_value;
        count_nxt = count_inc;
        if (flags.empty) begin
          head_nxt = tail_nxt;
        end
      end
      OP_PUSH_FRONT: begin
        head_nxt  = ptr_dec(head_r);
        wr_en     = 1'b1;
        wr_addr   = head_nxt;
        count_nxt = count_inc;
        if (flags.empty) begin
          tail_nxt = head_nxt;
        end
      end
      OP_POP_BACK: begin
        tail_nxt  = ptr_dec(tail_r);
        count_nxt = count_dec;
      end
      OP_POP_FRONT: begin
        head_nxt  = ptr_inc(head_r);
        count_nxt = count_dec;
      end
      OP_READ_FRONT: begin
        rd_en   = 1'b1;
        rd_addr = head_r;
      end
      OP_READ_BACK: begin
        rd_en   = 1'b1;
        rd_addr = tail_r;
      end
      OP_READ_AT: begin
        rd_en   = 1'b1;
        rd_addr = at_ptr;
      end
      OP_CLEAR: begin
        head_nxt  = '0;
        tail_nxt  = LAST_PTR;
        count_nxt = '0;
      end
      OP_SHRINK: begin
        tail_nxt  = shr_ptr;
        count_nxt = CNT_W'(in_count);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= LAST_PTR;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FILL_START) begin
      fill_val_r <= in_value;
      fill_tgt_r <= CNT_W'(in_count);
    end
    if (cmd.ld_out) begin
      data_r <= cmd.out_ram ? VALUE_W'(rd_data) : '0;
      occ_r  <= COUNT_W'(count_nxt);
      stat_r <= cmd.status;
    end
  end

  cdq_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(DATA_WIDTH'(wr_value)),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign res_data      = data_r;
  assign res_occupancy = occ_r;
  assign res_status    = stat_r;

  `CDQ_ASSERT(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY), "element count above capacity")
  `CDQ_ASSERT(a_empty_ptrs, count_r == '0, tail_r == ptr_dec(head_r), "empty deque with stray pointers")
  `CDQ_ASSERT(a_fill_below, cmd.op == OP_FILL_STEP, count_r < fill_tgt_r, "fill write past target")

endmodule

// ===== rtl/cdq_ctrl.sv =====
`include "assert_macros.svh"

module cdq_ctrl import cdq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [KIND_W-1:0] in_kind,
  output logic              out_tvalid,
  input  logic              out_tready,
  output cdq_cmd_t          cmd,
  input  cdq_flags_t        flags
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_FILL = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       acc;

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    cmd.op      = OP_NONE;
    cmd.ld_out  = 1'b0;
    cmd.out_ram = 1'b0;
    cmd.status  = ST_OK;
    state_nxt   = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          cmd.ld_out = 1'b1;
          unique case (in_kind)
            KIND_PUSH_BACK: begin
              if (flags.full) cmd.status = ST_FULL;
              else cmd.op = OP_PUSH_BACK;
            end
            KIND_PUSH_FRONT: begin
              if (flags.full) cmd.status = ST_FULL;
              else cmd.op = OP_PUSH_FRONT;
            end
            KIND_POP_BACK: begin
              if (flags.empty) cmd.status = ST_EMPTY;
              else cmd.op = OP_POP_BACK;
            end
            KIND_POP_FRONT: begin
              if (flags.empty) cmd.status = ST_EMPTY;
              else cmd.op = OP_POP_FRONT;
            end
            KIND_READ_FRONT, KIND_READ_BACK: begin
              if (flags.empty) begin
                cmd.status = ST_EMPTY;
              end else begin
                cmd.op     = (in_kind == KIND_READ_FRONT) ? OP_READ_FRONT : OP_READ_BACK;
                cmd.ld_out = 1'b0;
                state_nxt  = S_READ;
              end
            end
            KIND_READ_AT: begin
              if (!flags.idx_ok) begin
                cmd.status = ST_RANGE;
              end else begin
                cmd.op     = OP_READ_AT;
                cmd.ld_out = 1'b0;
                state_nxt  = S_READ;
              end
            end
            KIND_CLEAR: begin
              cmd.op = OP_CLEAR;
            end
            KIND_RESIZE: begin
              priority if (flags.cnt_over) begin
                cmd.status = ST_FULL;
              end else if (flags.cnt_grow) begin
                cmd.op     = OP_FILL_START;
                cmd.ld_out = 1'b0;
                state_nxt  = S_FILL;
              end else if (flags.cnt_shrink) begin
                cmd.op = OP_SHRINK;
              end else begin
                cmd.op = OP_NONE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        cmd.ld_out  = 1'b1;
        cmd.out_ram = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_FILL: begin
        cmd.op = OP_FILL_STEP;
        if (flags.fill_last) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.ld_out ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  `CDQ_ASSERT(a_read_slot_free, state_r == S_READ, !out_valid_r, "read result with output busy")
  `CDQ_ASSERT(a_fill_slot_free, state_r == S_FILL, !out_valid_r, "fill running with output busy")
  `CDQ_ASSERT_NXT(a_read_one_cycle, state_r == S_READ, state_r == S_IDLE, "read wait overran")

endmodule

// ===== rtl/circular_deque.sv =====
// Fixed-capacity double-ended queue over a circular store. Each input beat
// carries one operation in in_tuser (push back or front, pop back or front,
// read front, back or at an index from the front, clear, resize with fill)
// and yields exactly one output beat with the read data (zero unless a read
// succeeds), the element count after the operation and a status: ok, empty,
// index out of range, or full / target count above capacity. A push into a
// full deque and a resize beyond CAPACITY change nothing. Kinds 9 to 15 are
// answered with ok and no change. Pushes, pops, clear, truncating resizes
// and every refused operation load their result as the beat is taken;
// reads pass through a read state, because the element store is a RAM
// with a registered read port; a growing resize passes through a fill
// state that writes the appended elements one at a time, as the store has
// a single write port. Only one item is in work at a time. The result sits
// in an output register, so a new beat is taken in the same cycle that the
// previous result is taken. Occupancy is reported in 7 bits; store entries
// are DATA_WIDTH bits, extended or cut to the 32-bit value and data fields.
module circular_deque import cdq_pkg::*; #(
  parameter int CAPACITY   = CDQ_CAPACITY,
  parameter int DATA_WIDTH = CDQ_DATA_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // value[31:0], index[37:32], count[44:38]
  input  logic [KIND_W-1:0]      in_tuser,   // kind[3:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // data[31:0], occupancy[38:32]
  output logic [STATUS_W-1:0]    out_tuser   // status[1:0]
);

  cdq_cmd_t            cmd;
  cdq_flags_t          flags;
  logic [VALUE_W-1:0]  res_data;
  logic [COUNT_W-1:0]  res_occupancy;

  // The controller sequences each beat; the datapath owns the pointers,
  // the count, the store and the result register.
  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_kind   (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cmd       (cmd),
    .flags     (flags)
  );

  cdq_dp #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .flags        (flags),
    .in_value     (in_tdata[VALUE_W-1:0]),
    .in_index     (in_tdata[VALUE_W +: INDEX_W]),
    .in_count     (in_tdata[VALUE_W+INDEX_W +: COUNT_W]),
    .res_data     (res_data),
    .res_occupancy(res_occupancy),
    .res_status   (out_tuser)
  );

  // Pad bits above the occupancy read as zero.
  assign out_tdata = OUT_TDATA_W'({res_occupancy, res_data});

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import cdq_pkg::*;

  localparam int CAP       = CDQ_CAPACITY;
  localparam int MAX_SHOWN = 10;
  localparam int PER_PHASE = 500;
  localparam int HOLD_LEN  = 300;

  // Kinds that the block must answer with ok and leave the deque untouched.
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 4'd9;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 4'd15;

  typedef struct packed {
    logic [VALUE_W-1:0]  data;
    logic [COUNT_W-1:0]  occ;
    logic [STATUS_W-1:0] status;
  } result_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
    logic [COUNT_W-1:0] count;
    bit                 typed;  // want holds a hand-written result
    result_t            want;
  } script_row_t;

  localparam int SCRIPT_LEN = 28;

  // Columns: kind, value, index, count, typed, {data, occupancy, status}.
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{KIND_READ_FRONT, 32'h0,        6'd0,  7'd0,   1'b1, '{32'h0, 7'd0, ST_EMPTY}},
    '{KIND_POP_FRONT,  32'h0,        6'd0,  7'd0,   1'b1, '{32'h0, 7'd0, ST_EMPTY}},
    '{KIND_POP_BACK,   32'h0,        6'd0,  7'd0,   1'b1, '{32'h0, 7'd0, ST_EMPTY}},
    '{KIND_READ_BACK,  32'h0,        6'd0,  7'd0,   1'b1, '{32'h0, 7'd0, ST_EMPTY}},
    '{KIND_READ_AT,    32'h0,        6'd0,  7'd0,   1'b1, '{32'h0, 7'd0, ST_RANGE}},
    '{KIND_RESIZE,     32'h1,        6'd0,  7'd127, 1'b1, '{32'h0, 7'd0, ST_FULL}},
    '{KIND_RESIZE,     32'h1,        6'd0,  7'd0,   1'b1, '{32'h0, 7'd0, ST_OK}},
    '{KIND_PUSH_BACK,  32'h7FFFFFFF, 6'd0,  7'd0,   1'b1, '{32'h0, 7'd1, ST_OK}},
    '{KIND_PUSH_FRONT, 32'h80000000, 6'd0,  7'd0,   1'b1, '{32'h0, 7'd2, ST_OK}},
    '{KIND_READ_FRONT, 32'h0,        6'd0,  7'd0,   1'b1, '{32'h80000000, 7'd2, ST_OK}},
    '{KIND_READ_BACK,  32'h0,        6'd0,  7'd0,   1'b1, '{32'h7FFFFFFF, 7'd2, ST_OK}},
    '{KIND_READ_AT,    32'h0,        6'd1,  7'd0,   1'b1, '{32'h7FFFFFFF, 7'd2, ST_OK}},
    '{KIND_READ_AT,    32'h0,        6'd63, 7'd0,   1'b1, '{32'h0, 7'd2, ST_RANGE}},
    '{KIND_RESIZE,     32'hFFFFFFFF, 6'd0,  7'd64,  1'b1, '{32'h0, 7'd64, ST_OK}},
    '{KIND_PUSH_BACK,  32'h1,        6'd0,  7'd0,   1'b1, '{32'h0, 7'd64, ST_FULL}},
    '{KIND_PUSH_FRONT, 32'h2,        6'd0,  7'd0,   1'b1, '{32'h0, 7'd64, ST_FULL}},
    '{KIND_READ_AT,    32'h0,        6'd63, 7'd0,   1'b1, '{32'hFFFFFFFF, 7'd64, ST_OK}},
    '{KIND_RESIZE,     32'h3,        6'd0,  7'd65,  1'b1, '{32'h0, 7'd64, ST_FULL}},
    '{KIND_RESIZE,     32'h3,        6'd0,  7'd64,  1'b1, '{32'h0, 7'd64, ST_OK}},
    '{KIND_RESIZE,     32'h0,        6'd0,  7'd3,   1'b1, '{32'h0, 7'd3, ST_OK}},
    '{KIND_READ_BACK,  32'h0,        6'd0,  7'd0,   1'b0, '{32'h0, 7'd0, ST_OK}},
    '{KIND_POP_FRONT,  32'h0,        6'd0,  7'd0,   1'b1, '{32'h0, 7'd2, ST_OK}},
    '{KIND_SPARE_HI,   32'hDEADBEEF, 6'd5,  7'd9,   1'b1, '{32'h0, 7'd2, ST_OK}},
    '{KIND_SPARE_LO,   32'h12345678, 6'd0,  7'd0,   1'b1, '{32'h0, 7'd2, ST_OK}},
    '{KIND_READ_AT,    32'h0,        6'd1,  7'd0,   1'b0, '{32'h0, 7'd0, ST_OK}},
    '{KIND_CLEAR,      32'h0,        6'd0,  7'd0,   1'b1, '{32'h0, 7'd0, ST_OK}},
    '{KIND_PUSH_FRONT, 32'h5A5A0001, 6'd0,  7'd0,   1'b0, '{32'h0, 7'd0, ST_OK}},
    '{KIND_READ_BACK,  32'h0,        6'd0,  7'd0,   1'b0, '{32'h0, 7'd0, ST_OK}}
  };

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // value[31:0], index[37:32], count[44:38]
  logic [KIND_W-1:0]      in_tuser;   // kind[3:0]
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // data[31:0], occupancy[38:32]
  logic [STATUS_W-1:0]    out_tuser;  // status[1:0]

  // Shadow copy of the deque, advanced once per accepted input beat.
  logic [VALUE_W-1:0] shadow_store [CAP];
  int                 shadow_head;
  int                 shadow_tail;
  int                 shadow_count;

  result_t owed_results [$];
  int      mismatch_count = 0;
  int      send_idle_pct  = 0;
  int      recv_idle_pct  = 0;
  bit      hold_req       = 1'b0;
  int      hold_left      = 0;

  circular_deque uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  function automatic void shadow_clear();
    shadow_head  = 0;
    shadow_tail  = CAP - 1;
    shadow_count = 0;
  endfunction

  function automatic void shadow_append(input logic [VALUE_W-1:0] v);
    shadow_tail = (shadow_tail + 1) % CAP;
    shadow_store[shadow_tail] = v;
    if (shadow_count == 0) shadow_head = shadow_tail;
    shadow_count++;
  endfunction

  // Performs one operation on the shadow deque and returns its result beat.
  function automatic result_t apply_deque_op(input logic [KIND_W-1:0] kind,
                                             input logic [VALUE_W-1:0] value,
                                             input logic [INDEX_W-1:0] index,
                                             input logic [COUNT_W-1:0] count);
    result_t r;
    r = '0;
    r.status = ST_OK;
    case (kind)
      KIND_PUSH_BACK: begin
        if (shadow_count >= CAP) r.status = ST_FULL;
        else shadow_append(value);
      end
      KIND_PUSH_FRONT: begin
        if (shadow_count >= CAP) begin
          r.status = ST_FULL;
        end else begin
          shadow_head = (shadow_head + CAP - 1) % CAP;
          shadow_store[shadow_head] = value;
          if (shadow_count == 0) shadow_tail = shadow_head;
          shadow_count++;
        end
      end
      KIND_POP_BACK: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          shadow_tail = (shadow_tail + CAP - 1) % CAP;
          shadow_count--;
        end
      end
      KIND_POP_FRONT: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          shadow_head = (shadow_head + 1) % CAP;
          shadow_count--;
        end
      end
      KIND_READ_FRONT: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else r.data = shadow_store[shadow_head];
      end
      KIND_READ_BACK: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else r.data = shadow_store[shadow_tail];
      end
      KIND_READ_AT: begin
        if (int'(index) >= shadow_count) r.status = ST_RANGE;
        else r.data = shadow_store[(shadow_head + int'(index)) % CAP];
      end
      KIND_CLEAR: begin
        shadow_clear();
      end
      KIND_RESIZE: begin
        if (int'(count) > CAP) begin
          r.status = ST_FULL;
        end else if (int'(count) > shadow_count) begin
          while (shadow_count < int'(count)) shadow_append(value);
        end else if (int'(count) < shadow_count) begin
          // Truncation keeps the first count elements; the front stays put.
          shadow_tail  = (shadow_tail + CAP - (shadow_count - int'(count))) % CAP;
          shadow_count = int'(count);
        end
      end
      default: begin
      end
    endcase
    r.occ = COUNT_W'(shadow_count);
    return r;
  endfunction

  // Offers one beat, starting and ending at a falling edge. The expectation is
  // queued at the rising edge that accepts the beat.
  task automatic send_beat(input logic [KIND_W-1:0] kind,
                           input logic [VALUE_W-1:0] value,
                           input logic [INDEX_W-1:0] index,
                           input logic [COUNT_W-1:0] count,
                           input bit typed,
                           input result_t want);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = IN_TDATA_W'({count, index, value});
    do @(posedge clk); while (!in_tready);
    predicted = apply_deque_op(kind, value, index, count);
    owed_results.insert(owed_results.size(), typed ? want : predicted);
    @(negedge clk);
  endtask

  // Result side: random back-pressure, plus one long hold on request so the
  // deque backs up and stalls its input while the sender keeps offering.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        hold_left  = HOLD_LEN;
        out_tready = 1'b0;
      end else begin
        out_tready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    result_t seen;
    result_t due;
    if (rst_n && out_tvalid && out_tready) begin
      seen.data   = out_tdata[VALUE_W-1:0];
      seen.occ    = out_tdata[VALUE_W +: COUNT_W];
      seen.status = out_tuser;
      if (owed_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
          $display("%0t: result beat with none outstanding: data=%h occ=%0d status=%0d",
                   $time, seen.data, seen.occ, seen.status);
      end else begin
        due = owed_results[0];
        owed_results.delete(0);
        if (seen !== due) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN)
            $display("%0t: expected data=%h occ=%0d status=%0d, got data=%h occ=%0d status=%0d",
                     $time, due.data, due.occ, due.status,
                     seen.data, seen.occ, seen.status);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("** circular_deque: FAILED **");
    $finish;
  end

  initial begin
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
    logic [COUNT_W-1:0] count;
    int                 r;
    int                 lvl;
    int                 mode;
    int                 push_pct;
    int                 pop_pct;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = KIND_PUSH_BACK;
    in_tdata  = '0;
    mode      = 2;
    shadow_clear();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 32;
    recv_idle_pct = 45;
    for (int i = 0; i < SCRIPT_LEN; i++)
      send_beat(SCRIPT[i].kind, SCRIPT[i].value, SCRIPT[i].index, SCRIPT[i].count,
                SCRIPT[i].typed, SCRIPT[i].want);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 45 : 0;
      recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 32 : 0;
      for (int n = 0; n < PER_PHASE; n++) begin
        if (phase == 2 && n == 100) hold_req = 1'b1;
        // Drift between filling, draining and balanced traffic so the level
        // sweeps from empty to full and back, wrapping both pointers.
        if ($urandom_range(39) == 0) mode = $urandom_range(2);
        lvl = shadow_count;
        r = $urandom_range(99);
        if (r < 4) begin
          kind = KIND_W'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
        end else if (r < 6) begin
          kind = KIND_CLEAR;
        end else if (r < 13) begin
          kind = KIND_RESIZE;
        end else begin
          push_pct = (mode == 0) ? 60 : (mode == 1) ? 20 : 40;
          pop_pct  = (mode == 0) ? 15 : (mode == 1) ? 55 : 30;
          r = $urandom_range(99);
          if (r < push_pct) begin
            kind = $urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
          end else if (r < push_pct + pop_pct) begin
            kind = $urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT;
          end else begin
            case ($urandom_range(2))
              0: kind = KIND_READ_FRONT;
              1: kind = KIND_READ_BACK;
              default: kind = KIND_READ_AT;
            endcase
          end
        end

        case ($urandom_range(19))
          0: value = 32'h7FFFFFFF;
          1: value = 32'h80000000;
          2: value = '0;
          3: value = '1;
          default: value = $urandom;
        endcase

        // Mostly live positions, sometimes any position to hit the range error.
        if (lvl > 0 && $urandom_range(4) != 0) index = INDEX_W'($urandom_range(lvl - 1));
        else index = INDEX_W'($urandom_range(63));

        // Resize targets: mostly truncations or short growth, a few full-size
        // fills and a few targets beyond capacity.
        r = $urandom_range(9);
        if (r < 5) count = COUNT_W'($urandom_range(lvl));
        else if (r < 8) count = COUNT_W'((lvl + 8 > CAP) ? CAP : lvl + $urandom_range(8));
        else if (r == 8) count = COUNT_W'(CAP);
        else count = COUNT_W'($urandom_range(127, CAP + 1));

        send_beat(kind, value, index, count, 1'b0, '0);
      end
    end

    in_tvalid = 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("** circular_deque: PASSED **");
    end else begin
      $display("** circular_deque: FAILED **");
    end
    $finish;
  end

endmodule
